// ----- rtl/core/tmps_pkg.sv -----
// Shared types, codes and constants of the timed motor pattern sequencer.
// No dependencies; every other file takes names from here, by scope or by import.
`timescale 1ns / 1ps
`default_nettype none

package tmps_pkg;

  // Field and register widths
  localparam int MASK_W      = 8;
  localparam int LANE_W      = $clog2(MASK_W);
  localparam int COUNT_W     = 4;
  localparam int WORD_W      = 32;
  localparam int MODE_W      = 3;
  localparam int PWM_SEL_W   = 2;
  localparam int PERIOD_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Divider: bits retired per cycle and steps per division
  localparam int STEP_BITS   = 4;
  localparam int DIV_STEPS   = WORD_W / STEP_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Default motor parameter
  localparam int MAX_MOTORS_DEF = 8;

  typedef logic [MASK_W-1:0] mask_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_SELECT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_COUNT  = 2'd3;

  // Register reset values
  localparam logic [MODE_W-1:0]    MODE_RST   = 3'd0;
  localparam logic [PWM_SEL_W-1:0] PWM_RST    = 2'd0;
  localparam logic [PERIOD_W-1:0]  PERIOD_RST = 16'd1000;
  localparam logic [COUNT_W-1:0]   COUNT_RST  = 4'd5;

  // Pattern modes
  localparam logic [MODE_W-1:0] MODE_ONE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALL   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_THREE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ORDER = 3'd4;

  // PWM selections
  localparam logic [PWM_SEL_W-1:0] PWM_OFF    = 2'd0;
  localparam logic [PWM_SEL_W-1:0] PWM_TOGGLE = 2'd1;
  localparam logic [PWM_SEL_W-1:0] PWM_RANDOM = 2'd2;
  localparam logic [PWM_SEL_W-1:0] PWM_ON     = 2'd3;

  // Divisor source for a division
  typedef enum logic [1:0] {
    DV_N,
    DV_N1,
    DV_N2,
    DV_FREE
  } div_sel_t;

  // Pattern register update
  typedef enum logic [2:0] {
    AP_NONE,
    AP_PREP,
    AP_FULL,
    AP_ZERO,
    AP_ORDER,
    AP_ONE,
    AP_ADD,
    AP_SHUF
  } apply_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    apply_t   apply;
    logic     emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              fire;
    logic [MODE_W-1:0] mode;
    logic              few_lanes;
    logic              div_done;
    logic              out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/timed_motor_pattern_sequencer.sv -----
// Timed motor pattern sequencer: one item per millisecond tick.
// Item interval, accept to next ready: shortest for a tick with no event, then
// all/in-order/unknown modes, then one-random, random-block and three-random,
// each set by its divisions in the divider (4 bits a cycle); a busy output can
// stretch it. The result is shown in the cycle after ready returns. Synchronous
// active-low reset loads register defaults; clears timer, pattern, valid, pwm.
`timescale 1ns / 1ps
`default_nettype none

module timed_motor_pattern_sequencer #(
  parameter int MAX_MOTORS = tmps_pkg::MAX_MOTORS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tmps_pkg::WORD_W-1:0]         in_random_word,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [tmps_pkg::MASK_W-1:0]              out_motor_on_mask,
  output logic                                     out_pwm_on,
  input  wire logic                                cfg_we,
  input  wire logic [tmps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tmps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tmps_pkg::cmd_t    cmd;
  tmps_pkg::status_t status;

  // Sequencer
  tmps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  tmps_dp #(
    .MAX_MOTORS (MAX_MOTORS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_random_word    (in_random_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_motor_on_mask (out_motor_on_mask),
    .out_pwm_on        (out_pwm_on)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tmps_div.sv -----
// Iterative unsigned divider: 32-bit dividend by a small divisor (1 to 8),
// four quotient bits per cycle. Depends on tmps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmps_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [tmps_pkg::WORD_W-1:0]        dividend,
  input  wire logic [tmps_pkg::COUNT_W-1:0]       divisor,
  output logic                                    done,
  output logic [tmps_pkg::WORD_W-1:0]             quotient,
  output logic [tmps_pkg::LANE_W-1:0]             remainder
);

  localparam int W = tmps_pkg::WORD_W;
  localparam int S = tmps_pkg::STEP_BITS;

  logic [W-1:0]                    q_r;
  logic [tmps_pkg::LANE_W-1:0]     rem_r;
  logic [tmps_pkg::COUNT_W-1:0]    d_r;
  logic [tmps_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [W-1:0]                    q_nxt;
  logic [tmps_pkg::LANE_W-1:0]     rem_nxt;

  // Retire the top bits of the shift register against the divisor
  always_comb begin
    logic [tmps_pkg::LANE_W-1:0]  rem;
    logic [tmps_pkg::LANE_W:0]    part;
    logic [S-1:0]                 qbits;
    rem   = rem_r;
    qbits = '0;
    for (int j = 0; j < S; j++) begin
      part = {rem, q_r[W-1-j]};
      if (part >= d_r) begin
        part = part - d_r;
        qbits[S-1-j] = 1'b1;
      end
      rem = part[tmps_pkg::LANE_W-1:0];
    end
    rem_nxt = rem;
    q_nxt   = {q_r[W-S-1:0], qbits};
  end

  // Load, step and flag completion
  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (start) begin
      q_r    <= dividend;
      d_r    <= divisor;
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == tmps_pkg::DIV_CNT_W'(tmps_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/tmps_dp.sv -----
// Datapath: configuration registers, tick timer, pattern and block state,
// divider and output register. Depends on tmps_pkg and tmps_div.
`timescale 1ns / 1ps
`default_nettype none

module tmps_dp #(
  parameter int MAX_MOTORS = tmps_pkg::MAX_MOTORS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire tmps_pkg::cmd_t                        cmd,
  output tmps_pkg::status_t                          status,
  input  wire logic [tmps_pkg::WORD_W-1:0]           in_random_word,
  input  wire logic                                  cfg_we,
  input  wire logic [tmps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [tmps_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [tmps_pkg::MASK_W-1:0]                out_motor_on_mask,
  output logic                                       out_pwm_on
);

  localparam int MW = tmps_pkg::MASK_W;
  localparam int LW = tmps_pkg::LANE_W;
  localparam int CW = tmps_pkg::COUNT_W;
  localparam int PW = tmps_pkg::PERIOD_W;
  localparam logic [CW-1:0] LANE_CAP = CW'((MAX_MOTORS < MW) ? MAX_MOTORS : MW);

  // Index of the k-th lane that is in use and not yet taken
  function automatic logic [LW-1:0] nth_free(input tmps_pkg::mask_t used,
                                             input logic [LW-1:0] k,
                                             input tmps_pkg::mask_t full);
    logic [LW-1:0] idx;
    logic [LW:0]   cnt;
    logic          found;
    idx   = '0;
    cnt   = '0;
    found = 1'b0;
    for (int i = 0; i < MW; i++) begin
      if (full[i] && !used[i] && !found) begin
        if (cnt == {1'b0, k}) begin
          idx   = LW'(i);
          found = 1'b1;
        end
        cnt = cnt + 1'b1;
      end
    end
    return idx;
  endfunction

  // Configuration registers
  logic [tmps_pkg::MODE_W-1:0]    mode_r;
  logic [tmps_pkg::PWM_SEL_W-1:0] pwm_sel_r;
  logic [PW-1:0]                  period_r;
  logic [CW-1:0]                  count_r;

  // Block state
  logic [PW-1:0]        tick_r;
  logic                 started_r;
  logic                 fire_r;
  logic [tmps_pkg::WORD_W-1:0] word_r;
  tmps_pkg::mask_t      pattern_r;
  tmps_pkg::mask_t      served_r;
  logic [LW-1:0]        pos_r;
  logic                 pwm_r;
  tmps_pkg::mask_t      out_mask_r;
  logic                 out_valid_r;

  // Divider connection
  logic                        div_done;
  logic [tmps_pkg::WORD_W-1:0] div_q;
  logic [LW-1:0]               div_rem;
  logic [tmps_pkg::WORD_W-1:0] div_dividend;
  logic [CW-1:0]               div_divisor;

  // Derived values
  logic [CW-1:0]   lanes;
  logic [CW-1:0]   lanes_raw;
  tmps_pkg::mask_t full;
  logic [CW-1:0]   free_cnt;
  logic [PW-1:0]   period;
  logic [PW-1:0]   tick_inc;
  logic            fire_now;
  logic [LW-1:0]   order_cur;
  logic [CW-1:0]   order_inc;
  logic [LW-1:0]   shuf_lane;
  tmps_pkg::mask_t shuf_served;
  tmps_pkg::mask_t prep_served;
  logic            pwm_nxt;

  // Lane count and lane mask
  always_comb begin
    lanes_raw = (count_r == '0) ? CW'(1) : count_r;
    lanes     = (lanes_raw > LANE_CAP) ? LANE_CAP : lanes_raw;
    for (int i = 0; i < MW; i++) begin
      full[i] = (CW'(i) < lanes);
    end
  end

  // Count lanes still free in the current block
  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < MW; i++) begin
      free_cnt = free_cnt + CW'(full[i] & ~served_r[i]);
    end
  end

  // Tick timer: saturating count and event decision
  assign period   = (period_r == '0) ? PW'(1) : period_r;
  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 1'b1;
  assign fire_now = !started_r || (tick_inc >= period);

  // Round-robin and random-block helpers
  assign order_cur   = ({1'b0, pos_r} >= lanes) ? '0 : pos_r;
  assign order_inc   = {1'b0, order_cur} + 1'b1;
  assign shuf_lane   = nth_free(served_r, div_rem, full);
  assign shuf_served = served_r | (tmps_pkg::mask_t'(1) << shuf_lane);
  assign prep_served = ((served_r & full) == full) ? '0 : (served_r & full);

  // Divider operands
  always_comb begin
    div_dividend = word_r;
    div_divisor  = lanes;
    case (cmd.div_sel)
      tmps_pkg::DV_N: begin
        div_dividend = word_r;
        div_divisor  = lanes;
      end
      tmps_pkg::DV_N1: begin
        div_dividend = div_q;
        div_divisor  = lanes - CW'(1);
      end
      tmps_pkg::DV_N2: begin
        div_dividend = div_q;
        div_divisor  = lanes - CW'(2);
      end
      default: begin
        div_dividend = word_r;
        div_divisor  = free_cnt;
      end
    endcase
  end

  tmps_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Next pwm flag for an event
  always_comb begin
    unique case (pwm_sel_r)
      tmps_pkg::PWM_OFF:    pwm_nxt = 1'b0;
      tmps_pkg::PWM_TOGGLE: pwm_nxt = ~pwm_r;
      tmps_pkg::PWM_RANDOM: pwm_nxt = word_r[tmps_pkg::WORD_W-1];
      tmps_pkg::PWM_ON:     pwm_nxt = 1'b1;
      default:              pwm_nxt = 1'b1;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tmps_pkg::MODE_RST;
      pwm_sel_r <= tmps_pkg::PWM_RST;
      period_r  <= tmps_pkg::PERIOD_RST;
      count_r   <= tmps_pkg::COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmps_pkg::REG_PATTERN_MODE: mode_r    <= cfg_data[tmps_pkg::MODE_W-1:0];
        tmps_pkg::REG_PWM_SELECT:   pwm_sel_r <= cfg_data[tmps_pkg::PWM_SEL_W-1:0];
        tmps_pkg::REG_EVENT_PERIOD: period_r  <= cfg_data[PW-1:0];
        tmps_pkg::REG_MOTOR_COUNT:  count_r   <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Take the item: latch the word and advance the timer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_r <= in_random_word;
      fire_r <= fire_now;
      if (fire_now) begin
        tick_r    <= '0;
        started_r <= 1'b1;
      end else begin
        tick_r <= tick_inc;
      end
    end
    if (!rst_n) begin
      tick_r    <= '0;
      started_r <= 1'b0;
      fire_r    <= 1'b0;
    end
  end

  // Pattern, block and order updates
  always_ff @(posedge clk) begin
    case (cmd.apply)
      tmps_pkg::AP_PREP:  served_r  <= prep_served;
      tmps_pkg::AP_FULL:  pattern_r <= full;
      tmps_pkg::AP_ZERO:  pattern_r <= '0;
      tmps_pkg::AP_ORDER: begin
        pattern_r <= tmps_pkg::mask_t'(1) << order_cur;
        pos_r     <= (order_inc >= lanes) ? '0 : order_inc[LW-1:0];
      end
      tmps_pkg::AP_ONE:   pattern_r <= tmps_pkg::mask_t'(1) << div_rem;
      tmps_pkg::AP_ADD:
        pattern_r <= pattern_r | (tmps_pkg::mask_t'(1) << nth_free(pattern_r, div_rem, full));
      tmps_pkg::AP_SHUF: begin
        pattern_r <= tmps_pkg::mask_t'(1) << shuf_lane;
        if (shuf_served == full) begin
          served_r <= '0;
          pos_r    <= '0;
        end else begin
          served_r <= shuf_served;
          pos_r    <= pos_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (!rst_n) begin
      pattern_r <= '0;
      served_r  <= '0;
      pos_r     <= '0;
    end
  end

  // Output register and pwm flag
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_valid_r <= 1'b1;
      out_mask_r  <= pattern_r;
      pwm_r       <= pwm_nxt;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pwm_r       <= 1'b0;
    end
  end

  assign status = '{
    fire:      fire_r,
    mode:      mode_r,
    few_lanes: (lanes < CW'(3)),
    div_done:  div_done,
    out_free:  (!out_valid_r || out_ready)
  };

  assign out_valid         = out_valid_r;
  assign out_motor_on_mask = out_mask_r;
  assign out_pwm_on        = pwm_r;

endmodule

`default_nettype wire

// ----- rtl/core/tmps_ctrl.sv -----
// Controller: sequences timer check, divisions, pattern updates and output
// for one item at a time. Depends on tmps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tmps_pkg::status_t status,
  output tmps_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PREP,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic                rdy_r;
  logic                start_r;
  tmps_pkg::div_sel_t  sel_r;
  tmps_pkg::apply_t    apply_r;
  logic                emit_r;
  logic [1:0]          stage_r;

  // Sequence one item
  always_ff @(posedge clk) begin
    start_r <= 1'b0;
    apply_r <= tmps_pkg::AP_NONE;
    emit_r  <= 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rdy_r) begin
          rdy_r   <= 1'b0;
          state_r <= S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.fire) begin
          rdy_r   <= 1'b1;
          state_r <= S_IDLE;
        end else begin
          unique case (status.mode)
            tmps_pkg::MODE_ONE: begin
              start_r <= 1'b1;
              sel_r   <= tmps_pkg::DV_N;
              state_r <= S_DIV;
            end
            tmps_pkg::MODE_ALL: begin
              apply_r <= tmps_pkg::AP_FULL;
              state_r <= S_EMIT;
            end
            tmps_pkg::MODE_THREE: begin
              if (status.few_lanes) begin
                apply_r <= tmps_pkg::AP_FULL;
                state_r <= S_EMIT;
              end else begin
                start_r <= 1'b1;
                sel_r   <= tmps_pkg::DV_N;
                stage_r <= 2'd0;
                state_r <= S_DIV;
              end
            end
            tmps_pkg::MODE_BLOCK: begin
              apply_r <= tmps_pkg::AP_PREP;
              state_r <= S_PREP;
            end
            tmps_pkg::MODE_ORDER: begin
              apply_r <= tmps_pkg::AP_ORDER;
              state_r <= S_EMIT;
            end
            default: begin
              apply_r <= tmps_pkg::AP_ZERO;
              state_r <= S_EMIT;
            end
          endcase
        end
      end
      S_PREP: begin
        start_r <= 1'b1;
        sel_r   <= tmps_pkg::DV_FREE;
        state_r <= S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.mode == tmps_pkg::MODE_THREE) begin
            if (stage_r == 2'd0) begin
              apply_r <= tmps_pkg::AP_ONE;
              start_r <= 1'b1;
              sel_r   <= tmps_pkg::DV_N1;
              stage_r <= 2'd1;
            end else if (stage_r == 2'd1) begin
              apply_r <= tmps_pkg::AP_ADD;
              start_r <= 1'b1;
              sel_r   <= tmps_pkg::DV_N2;
              stage_r <= 2'd2;
            end else begin
              apply_r <= tmps_pkg::AP_ADD;
              state_r <= S_EMIT;
            end
          end else if (status.mode == tmps_pkg::MODE_BLOCK) begin
            apply_r <= tmps_pkg::AP_SHUF;
            state_r <= S_EMIT;
          end else begin
            apply_r <= tmps_pkg::AP_ONE;
            state_r <= S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          emit_r  <= 1'b1;
          rdy_r   <= 1'b1;
          state_r <= S_IDLE;
        end
      end
      default: state_r <= S_IDLE;
    endcase
    if (!rst_n) begin
      state_r <= S_IDLE;
      rdy_r   <= 1'b1;
      start_r <= 1'b0;
      sel_r   <= tmps_pkg::DV_N;
      apply_r <= tmps_pkg::AP_NONE;
      emit_r  <= 1'b0;
      stage_r <= 2'd0;
    end
  end

  assign in_ready = rdy_r;

  assign cmd = '{
    load:      (in_valid && rdy_r),
    div_start: start_r,
    div_sel:   sel_r,
    apply:     apply_r,
    emit:      emit_r
  };

endmodule

`default_nettype wire

// ----- tb/sv/tmps_pattern_checker.sv -----
// Checker for the timed motor pattern sequencer: mirrors the register file,
// predicts each pattern event from accepted ticks and compares results.
// Depends on tmps_pkg for widths, register indexes and mode codes.
`timescale 1ns / 1ps

module tmps_pattern_checker #(
  parameter int MAX_MOTORS = tmps_pkg::MAX_MOTORS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [tmps_pkg::WORD_W-1:0]         in_random_word,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [tmps_pkg::MASK_W-1:0]         out_motor_on_mask,
  input  logic                                out_pwm_on,
  input  logic                                cfg_we,
  input  logic [tmps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tmps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int unsigned                         fail_count,
  output int unsigned                         pending,
  output int unsigned                         ticks_seen,
  output int unsigned                         events_seen
);
  import tmps_pkg::*;

  typedef struct packed {
    mask_t motor_on_mask;
    logic  pwm_on;
  } motor_event_t;

  motor_event_t pattern_q[$];
  motor_event_t due_event;

  // Mirrored registers
  logic [MODE_W-1:0]    mode_reg;
  logic [PWM_SEL_W-1:0] pwm_reg;
  logic [PERIOD_W-1:0]  period_reg;
  logic [COUNT_W-1:0]   count_reg;

  // Mirrored sequencer state
  logic [15:0] tick_count;
  logic        started;
  mask_t       pattern_mask;
  mask_t       served_mask;
  logic [2:0]  order_pos;
  logic        pwm_flag;

  // Find the k-th motor below n not yet marked in used
  function automatic int unsigned nth_free_lane(int unsigned used, int unsigned k,
                                                int unsigned n);
    int unsigned left;
    left = k;
    for (int unsigned i = 0; i < n; i++) begin
      if (((used >> i) & 1) == 0) begin
        if (left == 0) return i;
        left--;
      end
    end
    return 0;
  endfunction

  // Advance the timer by one tick and queue the pattern event it causes, if any
  task automatic predict_tick(input logic [WORD_W-1:0] word);
    int unsigned r, lanes, full, period, a, b, c, m, free_n, pos;
    logic fire;
    motor_event_t ev;
    r = word;
    period = (period_reg == 0) ? 1 : 32'(period_reg);
    if (!started) begin
      fire = 1'b1;
    end else begin
      if (tick_count != 16'hFFFF) tick_count++;
      fire = (32'(tick_count) >= period);
    end
    if (!fire) return;
    started = 1'b1;
    tick_count = '0;

    // Clamp the motor count to the usable lanes
    lanes = 32'(count_reg);
    if (lanes == 0) lanes = 1;
    if (lanes > MAX_MOTORS) lanes = MAX_MOTORS;
    if (lanes > MASK_W) lanes = MASK_W;
    full = (1 << lanes) - 1;

    case (mode_reg)
      MODE_ONE: m = 1 << (r % lanes);
      MODE_ALL: m = full;
      MODE_THREE: begin
        if (lanes < 3) begin
          m = full;
        end else begin
          a = r % lanes;
          r = r / lanes;
          m = 1 << a;
          b = nth_free_lane(m, r % (lanes - 1), lanes);
          r = r / (lanes - 1);
          m = m | (1 << b);
          c = nth_free_lane(m, r % (lanes - 2), lanes);
          m = m | (1 << c);
        end
      end
      MODE_BLOCK: begin
        // Drop served bits above the count and restart a finished block
        served_mask = served_mask & mask_t'(full);
        if (32'(served_mask) == full) served_mask = '0;
        free_n = lanes - $countones(served_mask);
        a = nth_free_lane(32'(served_mask), r % free_n, lanes);
        served_mask = served_mask | mask_t'(1 << a);
        if (32'(served_mask) == full) begin
          served_mask = '0;
          order_pos = '0;
        end else begin
          order_pos = order_pos + 3'd1;
        end
        m = 1 << a;
      end
      MODE_ORDER: begin
        pos = 32'(order_pos);
        if (pos >= lanes) pos = 0;
        a = pos;
        pos = a + 1;
        if (pos >= lanes) pos = 0;
        order_pos = pos[2:0];
        m = 1 << a;
      end
      default: m = 0;
    endcase
    pattern_mask = m[MASK_W-1:0];

    case (pwm_reg)
      PWM_OFF:    pwm_flag = 1'b0;
      PWM_TOGGLE: pwm_flag = ~pwm_flag;
      PWM_RANDOM: pwm_flag = word[WORD_W-1];
      default:    pwm_flag = 1'b1;
    endcase

    ev.motor_on_mask = pattern_mask;
    ev.pwm_on = pwm_flag;
    pattern_q.push_back(ev);
  endtask

  // Track registers, predict on accepted ticks, compare accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_reg = MODE_RST;
      pwm_reg = PWM_RST;
      period_reg = PERIOD_RST;
      count_reg = COUNT_RST;
      tick_count = '0;
      started = 1'b0;
      pattern_mask = '0;
      served_mask = '0;
      order_pos = '0;
      pwm_flag = 1'b0;
      pattern_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_MODE: mode_reg = cfg_data[MODE_W-1:0];
          REG_PWM_SELECT:   pwm_reg = cfg_data[PWM_SEL_W-1:0];
          REG_EVENT_PERIOD: period_reg = cfg_data[PERIOD_W-1:0];
          REG_MOTOR_COUNT:  count_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        ticks_seen++;
        predict_tick(in_random_word);
      end
      if (out_valid && out_ready) begin
        if (pattern_q.size() == 0) begin
          $error("unexpected item: motor_on_mask %02h pwm_on %0b",
                 out_motor_on_mask, out_pwm_on);
          fail_count++;
        end else begin
          due_event = pattern_q.pop_front();
          events_seen++;
          if (out_motor_on_mask !== due_event.motor_on_mask) begin
            $error("motor_on_mask: expected %02h, got %02h",
                   due_event.motor_on_mask, out_motor_on_mask);
            fail_count++;
          end
          if (out_pwm_on !== due_event.pwm_on) begin
            $error("pwm_on: expected %0b, got %0b", due_event.pwm_on, out_pwm_on);
            fail_count++;
          end
        end
      end
    end
    pending = pattern_q.size();
  end

endmodule

// ----- tb/sv/tb_timed_motor_pattern_sequencer.sv -----
// Testbench top for the timed motor pattern sequencer: clock, reset, tick and
// register stimulus and the verdict. Depends on tmps_pkg and tmps_pattern_checker.
`timescale 1ns / 1ps

module tb_timed_motor_pattern_sequencer;
  import tmps_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int IDLE_PCT      = 9;
  localparam int RANDOM_TICKS  = 1350;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RESET_CYCLES  = 12;
  localparam int LONG_TICKS    = 100;
  // Pattern modes with no defined behaviour
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WORD_W-1:0]     in_random_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MASK_W-1:0]     out_motor_on_mask;
  logic                  out_pwm_on;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic        no_idle = 1'b0;
  int unsigned fail_count, pending, ticks_seen, events_seen;
  int unsigned ticks_sent = 0;
  int unsigned settings_applied = 0;
  int unsigned random_start;
  int unsigned cycle_count = 0;

  always #1 clk = ~clk;

  timed_motor_pattern_sequencer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_motor_on_mask(out_motor_on_mask),
    .out_pwm_on       (out_pwm_on),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  tmps_pattern_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_random_word   (in_random_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_motor_on_mask(out_motor_on_mask),
    .out_pwm_on       (out_pwm_on),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .ticks_seen       (ticks_seen),
    .events_seen      (events_seen)
  );

  // Stall the result side at random, except during the quiet stretch
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit, %0d results still due", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random word, with the all-zero and all-one words mixed in
  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom();
  endfunction

  // Random upper data bits, which the block must ignore for narrow registers
  function automatic logic [CFG_DATA_W-1:0] data_noise();
    if ($urandom_range(3) == 0) return CFG_DATA_W'($urandom());
    return '0;
  endfunction

  // Present one tick and hold it until accepted; call and return at a falling edge
  task automatic send_tick(input logic [WORD_W-1:0] word);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_random_word <= word;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic run_ticks(input int unsigned count);
    repeat (count) send_tick(pick_word());
  endtask

  // Drop valid, wait for every due result and let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // Write all four registers while the block is idle
  task automatic apply_setting(input logic [MODE_W-1:0] mode,
                               input logic [PWM_SEL_W-1:0] pwm,
                               input logic [PERIOD_W-1:0] period,
                               input logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] noise;
    settle();
    noise = data_noise();
    write_reg(REG_PATTERN_MODE, {noise[CFG_DATA_W-1:MODE_W], mode});
    noise = data_noise();
    write_reg(REG_PWM_SELECT, {noise[CFG_DATA_W-1:PWM_SEL_W], pwm});
    write_reg(REG_EVENT_PERIOD, period);
    noise = data_noise();
    write_reg(REG_MOTOR_COUNT, {noise[CFG_DATA_W-1:COUNT_W], count});
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Draw a setting biased towards short periods and in-range counts
  task automatic apply_random_setting();
    logic [MODE_W-1:0]    mode;
    logic [PERIOD_W-1:0]  period;
    logic [COUNT_W-1:0]   count;
    int unsigned          sel;
    if ($urandom_range(99) < 12) mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
    else mode = MODE_W'($urandom_range(MODE_ORDER, MODE_ONE));
    sel = $urandom_range(99);
    if (sel < 50) period = PERIOD_W'($urandom_range(3, 0));
    else if (sel < 85) period = PERIOD_W'($urandom_range(12, 4));
    else period = PERIOD_W'($urandom_range(60, 13));
    sel = $urandom_range(99);
    if (sel < 80) count = COUNT_W'($urandom_range(8, 1));
    else if (sel < 88) count = '0;
    else count = COUNT_W'($urandom_range(15, 9));
    apply_setting(mode, PWM_SEL_W'($urandom_range(3)), period, count);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First tick fires at once under the reset setting; the next must not
    send_tick('0);
    send_tick('1);
    // Zero period acts as one, all motors lit
    apply_setting(MODE_ALL, PWM_ON, 16'd0, 4'd8);
    send_tick('1);
    // Three-motor mode with too few motors lights them all
    apply_setting(MODE_THREE, PWM_TOGGLE, 16'd1, 4'd2);
    run_ticks(2);
    apply_setting(MODE_THREE, PWM_RANDOM, 16'd1, 4'd8);
    send_tick('1);
    send_tick('0);
    send_tick(32'h7FFF_FFFF);
    // Start a random block, then lower the count mid-block
    apply_setting(MODE_BLOCK, PWM_RANDOM, 16'd1, 4'd8);
    run_ticks(3);
    apply_setting(MODE_BLOCK, PWM_OFF, 16'd1, 4'd3);
    run_ticks(3);
    // Round-robin carries on from the shared position; oversized count clamps
    apply_setting(MODE_ORDER, PWM_TOGGLE, 16'd2, 4'd15);
    run_ticks(4);
    apply_setting(MODE_ONE, PWM_ON, 16'd1, 4'd0);
    run_ticks(2);
    // Undefined modes clear the mask but still give a result
    apply_setting(MODE_SPARE_HI, PWM_TOGGLE, 16'd1, 4'd8);
    send_tick(pick_word());
    apply_setting(MODE_SPARE_LO, PWM_RANDOM, 16'd1, 4'd8);
    send_tick('1);

    // Random phases, with one stretch free of idling on both sides
    random_start = ticks_sent;
    while (ticks_sent - random_start < RANDOM_TICKS) begin
      apply_random_setting();
      no_idle = (ticks_sent - random_start >= 600) && (ticks_sent - random_start < 900);
      run_ticks($urandom_range(60, 15));
    end
    no_idle = 1'b0;

    // Longest period: no event may follow within a short run of ticks
    apply_setting(MODE_BLOCK, PWM_TOGGLE, 16'hFFFF, 4'd8);
    run_ticks(LONG_TICKS);
    settle();

    $display("Covered %0d ticks over %0d register settings, longest period set last.",
             ticks_seen, settings_applied);
    $display("%0d pattern events compared, %0d failures.", events_seen, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/tmps_pkg.sv
rtl/core/tmps_div.sv
rtl/core/tmps_dp.sv
rtl/core/tmps_ctrl.sv
rtl/core/timed_motor_pattern_sequencer.sv
tb/sv/tmps_pattern_checker.sv
tb/sv/tb_timed_motor_pattern_sequencer.sv
